// File: hdl/gtm_pkg.sv
// Shared constants, command and status types for the Goertzel tone magnitude block.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package gtm_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_BLOCK_DEF    = 4096;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int STATE_WIDTH_DEF  = 48;

    // Fixed field widths and formats.
    localparam int COEF_W      = 16;
    localparam int COEF_FRAC   = 14;
    localparam int BLEN_W      = 13;
    localparam int MAG_W       = 48;
    localparam int MUL_DIGIT_W = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_COEFFICIENT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 2'd1;

    localparam logic [COEF_W-1:0] COEF_RESET = 16'sd0;
    localparam logic [BLEN_W-1:0] BLEN_RESET = 13'd256;

    // Operand choice for the shared multiplier.
    typedef enum logic [1:0] {
        MUL_A1SQ  = 2'd0,
        MUL_A2SQ  = 2'd1,
        MUL_CROSS = 2'd2
    } mul_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     step;
        logic     prod_load;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     acc_add_sq;
        logic     acc_add_cross;
        logic     eval;
        logic     out_load;
    } gtm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic block_end;
        logic mul_done;
        logic sqrt_done;
        logic out_free;
    } gtm_status_t;

endpackage

`default_nettype wire

// File: hdl/gtm_stream_if.sv
// Valid/ready stream interfaces for the sample input and the magnitude result.
// Depends on gtm_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface gtm_sample_if #(
    parameter int SAMPLE_WIDTH = gtm_pkg::SAMPLE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface gtm_result_if;
    logic                       valid;
    logic                       ready;
    logic [gtm_pkg::MAG_W-1:0]  magnitude;
    logic                       energy_nonpositive;

    modport source (output valid, output magnitude, output energy_nonpositive, input ready);
    modport sink   (input valid, input magnitude, input energy_nonpositive, output ready);
endinterface

`default_nettype wire

// File: hdl/gtm_mul.sv
// Iterative unsigned multiplier: one 16-bit digit of the B operand per cycle, MSB first.
// Depends on gtm_pkg for the digit width.
`timescale 1ns / 1ps
`default_nettype none

module gtm_mul #(
    parameter int AW = 64,
    parameter int BW = 48
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [AW-1:0]    a,
    input  wire logic [BW-1:0]    b,
    output logic                  done,
    output logic [AW+BW-1:0]      product
);
    import gtm_pkg::*;

    localparam int DW   = MUL_DIGIT_W;
    localparam int ND   = (BW + DW - 1) / DW;
    localparam int BPW  = ND * DW;
    localparam int ACCW = AW + BPW;
    localparam int CNTW = $clog2(ND + 1);

    logic [AW-1:0]   a_reg;
    logic [BPW-1:0]  b_reg;
    logic [ACCW-1:0] acc_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [AW+DW-1:0] partial;
    logic [ACCW-1:0]  acc_next;

    // One partial product per cycle, folded into the shifted accumulator.
    assign partial  = a_reg * b_reg[BPW-1 -: DW];
    assign acc_next = {acc_reg[ACCW-DW-1:0], {DW{1'b0}}} + ACCW'(partial);

    // Sequencing of the digit steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(ND);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= BPW'(b);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg   <= {b_reg[BPW-DW-1:0], {DW{1'b0}}};
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg[AW+BW-1:0];

endmodule

`default_nettype wire

// File: hdl/gtm_sqrt.sv
// Restoring integer square root, one result bit per cycle.
// Depends on gtm_pkg only through the common import convention.
`timescale 1ns / 1ps
`default_nettype none

module gtm_sqrt #(
    parameter int RADW = 98
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [RADW-1:0]    radicand,
    output logic                    done,
    output logic [RADW/2-1:0]       root
);
    import gtm_pkg::*;

    localparam int ROOTW = RADW / 2;
    localparam int REMW  = ROOTW + 2;
    localparam int CNTW  = $clog2(ROOTW + 1);

    logic [RADW-1:0]  rad_reg;
    logic [REMW-1:0]  rem_reg;
    logic [ROOTW-1:0] root_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [REMW-1:0]  rem_shift;
    logic [REMW-1:0]  trial;
    logic             fits;

    // Bring down two radicand bits and try the next root bit.
    assign rem_shift = {rem_reg[ROOTW-1:0], rad_reg[RADW-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(ROOTW);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Remainder and partial root.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[RADW-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[ROOTW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[ROOTW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// File: hdl/gtm_datapath.sv
// Datapath: configuration registers, Goertzel recurrence, energy accumulator and result register.
// Depends on gtm_pkg, gtm_mul and gtm_sqrt.
`timescale 1ns / 1ps
`default_nettype none

module gtm_datapath #(
    parameter int MAX_BLOCK    = gtm_pkg::MAX_BLOCK_DEF,
    parameter int SAMPLE_WIDTH = gtm_pkg::SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH  = gtm_pkg::STATE_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [gtm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gtm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [SAMPLE_WIDTH-1:0]           sample,
    input  wire gtm_pkg::gtm_cmd_t                 cmd,
    output gtm_pkg::gtm_status_t                   status,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [gtm_pkg::MAG_W-1:0]              magnitude,
    output logic                                   energy_nonpositive
);
    import gtm_pkg::*;

    localparam int SW    = STATE_WIDTH;
    localparam int PW    = COEF_W + SW;
    localparam int SUMW  = PW + 2;
    localparam int PRODW = PW + SW;
    localparam int EW    = 2 * SW + COEF_W + 1;
    localparam int RADW  = EW - 1 - COEF_FRAC;
    localparam int ROOTW = RADW / 2;
    localparam int MAXW  = (ROOTW > MAG_W) ? ROOTW : MAG_W;
    localparam int CNTW  = $clog2(MAX_BLOCK + 1);

    logic signed [COEF_W-1:0] coef_reg;
    logic [BLEN_W-1:0]        blen_reg;
    logic signed [SW-1:0]     s1_reg;
    logic signed [SW-1:0]     s2_reg;
    logic [CNTW-1:0]          count_reg;
    logic [PW-1:0]            pmag_reg;
    logic                     cneg_reg;
    logic [EW-1:0]            energy_reg;
    logic                     nonpos_reg;
    logic                     out_valid_reg;
    logic [MAG_W-1:0]         mag_out_reg;
    logic                     flag_out_reg;

    logic signed [PW-1:0]     mac_prod;
    logic signed [PW-1:0]     mac_shift;
    logic signed [SUMW-1:0]   mac_sum;
    logic signed [SW-1:0]     s0_sat;
    logic [CNTW-1:0]          len_eff;
    logic [CNTW-1:0]          count_inc;
    logic                     block_end;
    logic [SW-1:0]            a1;
    logic [SW-1:0]            a2;
    logic [PW-1:0]            mul_a;
    logic [SW-1:0]            mul_b;
    logic                     mul_done;
    logic [PRODW-1:0]         mul_product;
    logic [EW-1:0]            sq_term;
    logic [EW-1:0]            cross_term;
    logic                     energy_low;
    logic                     sqrt_done;
    logic [ROOTW-1:0]         root;
    logic [MAXW-1:0]          root_ext;
    logic [MAG_W-1:0]         root_sat;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
            blen_reg <= BLEN_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_COEFFICIENT)
            begin
                coef_reg <= cfg_data[COEF_W-1:0];
            end
            else if (cfg_index == REG_BLOCK_LENGTH)
            begin
                blen_reg <= cfg_data[BLEN_W-1:0];
            end
        end
    end

    // Recurrence: s0 = x + floor(c * s1 / 2^14) - s2, saturated to the state width.
    assign mac_prod  = coef_reg * s1_reg;
    assign mac_shift = mac_prod >>> COEF_FRAC;
    assign mac_sum   = SUMW'($signed(sample)) + SUMW'(mac_shift) - SUMW'(s2_reg);

    always_comb
    begin
        if (mac_sum[SUMW-1:SW-1] == '0 || mac_sum[SUMW-1:SW-1] == '1)
        begin
            s0_sat = mac_sum[SW-1:0];
        end
        else if (mac_sum[SUMW-1])
        begin
            s0_sat = {1'b1, {(SW-1){1'b0}}};
        end
        else
        begin
            s0_sat = {1'b0, {(SW-1){1'b1}}};
        end
    end

    // Effective block length: zero counts as one, large values clamp to the maximum.
    always_comb
    begin
        priority if (blen_reg == '0)
        begin
            len_eff = CNTW'(1);
        end
        else if (int'(blen_reg) > MAX_BLOCK)
        begin
            len_eff = CNTW'(MAX_BLOCK);
        end
        else
        begin
            len_eff = CNTW'(blen_reg);
        end
    end

    assign count_inc = count_reg + 1'b1;
    assign block_end = (count_inc >= len_eff);

    // Filter state and sample counter; state clears once the energy is captured.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg    <= '0;
            s2_reg    <= '0;
            count_reg <= '0;
        end
        else if (cmd.step)
        begin
            s2_reg    <= s1_reg;
            s1_reg    <= s0_sat;
            count_reg <= block_end ? '0 : count_inc;
        end
        else if (cmd.eval)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
    end

    // Magnitudes of the final state words.
    assign a1 = s1_reg[SW-1] ? SW'(-s1_reg) : SW'(s1_reg);
    assign a2 = s2_reg[SW-1] ? SW'(-s2_reg) : SW'(s2_reg);

    // Operand select for the shared multiplier.
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_A1SQ:
            begin
                mul_a = PW'(a1);
                mul_b = a1;
            end
            MUL_A2SQ:
            begin
                mul_a = PW'(a2);
                mul_b = a2;
            end
            MUL_CROSS:
            begin
                mul_a = pmag_reg;
                mul_b = a2;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    gtm_mul #(
        .AW (PW),
        .BW (SW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    // Energy scaled by 2^14: (s1^2 + s2^2) * 2^14 minus c * s1 * s2.
    assign sq_term    = EW'({mul_product, {COEF_FRAC{1'b0}}});
    assign cross_term = EW'(mul_product);

    always_ff @(posedge clk)
    begin
        if (cmd.prod_load)
        begin
            pmag_reg   <= mac_prod[PW-1] ? PW'(-mac_prod) : PW'(mac_prod);
            cneg_reg   <= mac_prod[PW-1] ^ s2_reg[SW-1];
            energy_reg <= '0;
        end
        else if (cmd.acc_add_sq)
        begin
            energy_reg <= energy_reg + sq_term;
        end
        else if (cmd.acc_add_cross)
        begin
            energy_reg <= cneg_reg ? energy_reg + cross_term : energy_reg - cross_term;
        end
    end

    // Energy below one unit after the shift, or negative, flags a nonpositive bin.
    assign energy_low = energy_reg[EW-1] || (energy_reg[EW-2:COEF_FRAC] == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            nonpos_reg <= energy_low;
        end
    end

    gtm_sqrt #(
        .RADW (RADW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.eval),
        .radicand (energy_reg[EW-2:COEF_FRAC]),
        .done     (sqrt_done),
        .root     (root)
    );

    // Clamp the root to the output width.
    assign root_ext = MAXW'(root);
    assign root_sat = (root_ext > MAXW'({MAG_W{1'b1}})) ? {MAG_W{1'b1}} : root_ext[MAG_W-1:0];

    // Output register; frees the datapath while a result waits for its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            mag_out_reg  <= nonpos_reg ? '0 : root_sat;
            flag_out_reg <= nonpos_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign magnitude          = mag_out_reg;
    assign energy_nonpositive = flag_out_reg;

    assign status.block_end = block_end;
    assign status.mul_done  = mul_done;
    assign status.sqrt_done = sqrt_done;
    assign status.out_free  = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

// File: hdl/gtm_ctrl.sv
// Controller state machine: sample acceptance and the block-end energy and root sequence.
// Depends on gtm_pkg for the command and status types.
`timescale 1ns / 1ps
`default_nettype none

module gtm_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire gtm_pkg::gtm_status_t  status,
    output gtm_pkg::gtm_cmd_t          cmd
);
    import gtm_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PROD  = 8'b0000_0010,
        ST_SQ1   = 8'b0000_0100,
        ST_SQ2   = 8'b0000_1000,
        ST_CROSS = 8'b0001_0000,
        ST_EVAL  = 8'b0010_0000,
        ST_SQRT  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_A1SQ;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.step = 1'b1;
                    if (status.block_end)
                    begin
                        state_next = ST_PROD;
                    end
                end
            end
            ST_PROD:
            begin
                cmd.prod_load = 1'b1;
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_A1SQ;
                state_next    = ST_SQ1;
            end
            ST_SQ1:
            begin
                if (status.mul_done)
                begin
                    cmd.acc_add_sq = 1'b1;
                    cmd.mul_start  = 1'b1;
                    cmd.mul_sel    = MUL_A2SQ;
                    state_next     = ST_SQ2;
                end
            end
            ST_SQ2:
            begin
                if (status.mul_done)
                begin
                    cmd.acc_add_sq = 1'b1;
                    cmd.mul_start  = 1'b1;
                    cmd.mul_sel    = MUL_CROSS;
                    state_next     = ST_CROSS;
                end
            end
            ST_CROSS:
            begin
                if (status.mul_done)
                begin
                    cmd.acc_add_cross = 1'b1;
                    state_next        = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (status.sqrt_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/goertzel_tone_magnitude.sv
// Top level of the single-bin Goertzel tone magnitude detector.
// Depends on gtm_pkg, the stream interfaces, gtm_ctrl and gtm_datapath.
//
// Samples are taken one per cycle while a block is running; each runs the recurrence
// s0 = x + floor(c*s1/2^14) - s2 in saturating STATE_WIDTH-bit state. The sample that
// completes a block of block_length samples starts the block-end sequence, during which
// no sample is taken: three products on a multiplier that consumes 16 bits of one operand
// per cycle, then an integer square root that yields one bit per cycle. After that
// sequence, once the output register is free, the magnitude is loaded into it and the
// next block begins. A block whose energy is zero or negative gives magnitude 0 with
// energy_nonpositive set. Write coefficient (index 0) and block_length (index 1) only
// while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module goertzel_tone_magnitude #(
    parameter int MAX_BLOCK    = gtm_pkg::MAX_BLOCK_DEF,
    parameter int SAMPLE_WIDTH = gtm_pkg::SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH  = gtm_pkg::STATE_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [gtm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gtm_pkg::CFG_DATA_W-1:0]    cfg_data,
    gtm_sample_if.sink                             samples,
    gtm_result_if.source                           results
);
    import gtm_pkg::*;

    gtm_cmd_t    cmd;
    gtm_status_t status;

    // Sequencer.
    gtm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic, state and result register.
    gtm_datapath #(
        .MAX_BLOCK    (MAX_BLOCK),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STATE_WIDTH  (STATE_WIDTH)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .sample             (samples.sample),
        .cmd                (cmd),
        .status             (status),
        .out_ready          (results.ready),
        .out_valid          (results.valid),
        .magnitude          (results.magnitude),
        .energy_nonpositive (results.energy_nonpositive)
    );

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the goertzel_tone_magnitude single-bin detector.
// Depends on gtm_pkg, the stream interfaces in gtm_stream_if and the block's RTL.
// A scoreboard class predicts each block-end magnitude; plain tasks drive the ports.
`timescale 1ns / 1ps

module tb;

    import gtm_pkg::*;

    localparam int     HALF_PERIOD    = 6;
    localparam int     RESET_CYCLES   = 10;
    localparam int     SETTLE_CYCLES  = 80;
    localparam int     TAIL_CYCLES    = 100;
    localparam int     LONG_HOLD      = 400;
    localparam int     RANDOM_ITEMS   = 1570;
    localparam int     QUIET_ITEMS    = 200;
    localparam int     BIG_PHASE      = 8;
    localparam longint TIMEOUT_NS     = 64'd50_000_000;
    localparam longint STATE_MAX      = (longint'(1) <<< (STATE_WIDTH_DEF - 1)) - 1;

    // Register indexes that the block decodes as unused.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    typedef struct {
        logic [MAG_W-1:0] magnitude;
        logic             nonpositive;
    } tone_result_t;

    // Tracks the Goertzel recurrence and queues the magnitude that each block end yields.
    class magnitude_scoreboard;
        logic signed [COEF_W-1:0]          coef;
        logic        [BLEN_W-1:0]          blen;
        logic signed [STATE_WIDTH_DEF-1:0] s1;
        logic signed [STATE_WIDTH_DEF-1:0] s2;
        int                                taken;
        int                                failures;
        tone_result_t                      expected_magnitudes[$];

        function new();
            coef     = COEF_RESET;
            blen     = BLEN_RESET;
            s1       = '0;
            s2       = '0;
            taken    = 0;
            failures = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            if (index == REG_COEFFICIENT)
                coef = data[COEF_W-1:0];
            else if (index == REG_BLOCK_LENGTH)
                blen = data[BLEN_W-1:0];
        endfunction

        function void note_failure(string what);
            failures++;
            if (failures <= 10)
                $display("%0t: %s", $realtime, what);
        endfunction

        // One recurrence step; at block end, the energy and its floor square root.
        function void take_sample(logic [15:0] raw);
            longint              x;
            longint              prod;
            longint              sum;
            int                  span;
            int                  b;
            logic signed [127:0] w1;
            logic signed [127:0] w2;
            logic signed [127:0] wc;
            logic signed [127:0] e14;
            logic signed [127:0] energy;
            logic        [127:0] rem;
            logic        [127:0] cand;
            logic        [127:0] root;
            tone_result_t        res;

            x    = longint'($signed(raw));
            prod = longint'(coef) * longint'(s1);
            sum  = x + (prod >>> COEF_FRAC) - longint'(s2);
            if (sum > STATE_MAX)
                sum = STATE_MAX;
            else if (sum < -STATE_MAX - 1)
                sum = -STATE_MAX - 1;
            s2 = s1;
            s1 = sum[STATE_WIDTH_DEF-1:0];

            // A length of zero acts as one; lengths past the maximum saturate.
            if (blen == 0)
                span = 1;
            else if (blen > MAX_BLOCK_DEF)
                span = MAX_BLOCK_DEF;
            else
                span = int'(blen);
            taken++;
            if (taken < span)
                return;

            w1     = s1;
            w2     = s2;
            wc     = coef;
            e14    = ((w1 * w1 + w2 * w2) <<< COEF_FRAC) - wc * w1 * w2;
            energy = e14 >>> COEF_FRAC;
            if (energy <= 0)
            begin
                res.magnitude   = '0;
                res.nonpositive = 1'b1;
            end
            else
            begin
                rem  = energy;
                root = '0;
                for (b = MAG_W; b >= 0; b--)
                begin
                    cand = root | (128'd1 << b);
                    if (cand * cand <= rem)
                        root = cand;
                end
                res.magnitude   = (root > MAG_MAX) ? MAG_MAX : root[MAG_W-1:0];
                res.nonpositive = 1'b0;
            end
            expected_magnitudes.push_back(res);
            s1    = '0;
            s2    = '0;
            taken = 0;
        endfunction

        function void check_magnitude(logic [MAG_W-1:0] magnitude, logic nonpositive);
            tone_result_t want;
            if (expected_magnitudes.size() == 0)
            begin
                note_failure($sformatf("unexpected result: magnitude %0d flag %0b",
                                       magnitude, nonpositive));
                return;
            end
            want = expected_magnitudes.pop_front();
            if (magnitude !== want.magnitude)
                note_failure($sformatf("magnitude: expected %0d, actual %0d",
                                       want.magnitude, magnitude));
            if (nonpositive !== want.nonpositive)
                note_failure($sformatf("energy_nonpositive: expected %0b, actual %0b",
                                       want.nonpositive, nonpositive));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit idling_enabled = 1'b1;
    int hold_requests  = 0;

    magnitude_scoreboard scoreboard;

    gtm_sample_if sample_ch ();
    gtm_result_if result_ch ();

    goertzel_tone_magnitude DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (sample_ch),
        .results   (result_ch)
    );

    always #HALF_PERIOD clk = ~clk;

    // Offer one sample, after an occasional idle burst, and hold it until the transfer.
    task automatic send_sample(input logic [15:0] value);
        if (idling_enabled && $urandom_range(0, 5) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= value;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        scoreboard.take_sample(value);
    endtask

    // Stop offering and wait until every predicted magnitude has been received.
    task automatic wait_for_drain();
        sample_ch.valid <= 1'b0;
        while (scoreboard.expected_magnitudes.size() != 0)
            @(posedge clk);
    endtask

    // Registers change only once the block has gone quiet.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        scoreboard.write_register(index, data);
    endtask

    // Result side: check each transfer, then decide ready for the next cycle.
    initial
    begin : result_sink
        int stall_left;
        int holds_granted;
        stall_left      = 0;
        holds_granted   = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                scoreboard.check_magnitude(result_ch.magnitude,
                                           result_ch.energy_nonpositive);
            if (hold_requests != holds_granted)
            begin
                holds_granted++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (idling_enabled && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int                    sent;
        int                    phase;
        int                    count;
        int                    mode;
        int                    span;
        int                    n;
        logic [15:0]           value;
        logic [15:0]           amp;
        logic [CFG_DATA_W-1:0] data;

        scoreboard       = new();
        rst_n            = 1'b0;
        cfg_write        = 1'b0;
        cfg_index        = REG_COEFFICIENT;
        cfg_data         = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: three samples stay inside the 256-sample block.
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0001);

        // Lowering the length below the count: the next sample closes the block.
        // The upper data bits lie outside the length field.
        write_register(REG_BLOCK_LENGTH, 16'hE002);
        send_sample(16'h0005);

        // A length of zero means every sample is a block; zero input has no energy.
        write_register(REG_COEFFICIENT, 16'h7FFF);
        write_register(REG_BLOCK_LENGTH, 16'h0000);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        send_sample(16'h7FFF);
        send_sample(16'h8000);

        // Coefficient -2.0 with a constant pair cancels to zero energy from nonzero state.
        write_register(REG_COEFFICIENT, 16'h8000);
        write_register(REG_BLOCK_LENGTH, 16'd2);
        send_sample(16'd1000);
        send_sample(16'd1000);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8001);

        // Writes to unused indexes must not disturb either register.
        write_register(REG_SPARE_A, 16'($urandom_range(0, 65535)));
        write_register(REG_SPARE_B, 16'($urandom_range(0, 65535)));
        write_register(REG_COEFFICIENT, 16'h4000);
        write_register(REG_BLOCK_LENGTH, 16'd3);
        send_sample(16'd12345);
        send_sample(16'hFFFE);
        send_sample(16'd7);

        // Output back-pressure: short blocks pile up behind a long receiver hold.
        write_register(REG_COEFFICIENT, 16'($urandom_range(0, 65535)));
        write_register(REG_BLOCK_LENGTH, 16'd2);
        hold_requests++;
        for (n = 0; n < 60; n++)
            send_sample(16'($urandom_range(0, 65535)));
        wait_for_drain();

        // Random phases: a fresh coefficient, usually a fresh length, then a run of samples of one flavor.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0:       data = 16'h8000;
                1:       data = 16'h7FFF;
                2:       data = 16'h0000;
                3:       data = 16'h4000;
                default: data = 16'($urandom_range(0, 65535));
            endcase
            write_register(REG_COEFFICIENT, data);

            if (phase == BIG_PHASE)
            begin
                // The longest length, written past the maximum; the block stays open.
                write_register(REG_BLOCK_LENGTH, 16'h1FFF);
                span = MAX_BLOCK_DEF;
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 15))
                    0:         span = 0;
                    1:         span = 1;
                    2:         span = 256;
                    3, 4, 5:   span = $urandom_range(2, 8);
                    default:   span = $urandom_range(2, 40);
                endcase
                data = {3'($urandom_range(0, 7)), 13'(span)};
                write_register(REG_BLOCK_LENGTH, data);
            end
            else
                span = int'(scoreboard.blen);
            if (span == 0)
                span = 1;
            else if (span > MAX_BLOCK_DEF)
                span = MAX_BLOCK_DEF;

            count = (phase == BIG_PHASE) ? $urandom_range(1, 40)
                                         : $urandom_range(1, 3 * span + 5);
            if (count > RANDOM_ITEMS - sent)
                count = RANDOM_ITEMS - sent;
            mode  = $urandom_range(0, 3);
            amp   = 16'($urandom_range(16384, 32767));
            for (n = 0; n < count; n++)
            begin
                case (mode)
                    0: value = 16'($urandom_range(0, 65535));
                    1:
                    begin
                        case ($urandom_range(0, 3))
                            0:       value = 16'h7FFF;
                            1:       value = 16'h8000;
                            2:       value = 16'h0000;
                            default: value = 16'hFFFF;
                        endcase
                    end
                    2: value = 16'($urandom_range(0, 8)) - 16'd4;
                    default: value = n[0] ? -amp : amp;
                endcase
                send_sample(value);
                sent++;
                if (sent >= RANDOM_ITEMS - QUIET_ITEMS)
                    idling_enabled = 1'b0;
            end
            phase++;
        end

        // Wait for every predicted magnitude, then allow for stray results.
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (scoreboard.failures == 0 && scoreboard.expected_magnitudes.size() == 0)
            $display("goertzel_tone_magnitude regression: pass");
        else
            $display("goertzel_tone_magnitude regression: fail");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("goertzel_tone_magnitude regression: fail");
        $finish;
    end

endmodule
